/* hdl/ascii_status_frame_parser_core_defines.svh */
// assertion macros shared by the parser checker
`ifndef ASCII_STATUS_FRAME_PARSER_CORE_DEFINES_SVH
`define ASCII_STATUS_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ASFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asfp checker: property failed");

// next-cycle implication, checked outside reset
`define ASFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asfp checker: property failed");

`endif

/* hdl/asfp_pkg.sv */
// types, constants and tables of the ascii status frame parser
package asfp_pkg;

  localparam int unsigned HDR_W   = 32;
  localparam int unsigned VALUE_W = 28;

  localparam logic [5:0] HEADER_LAST = 6'd3;
  localparam logic [5:0] STATUS_BASE = 6'd56;
  localparam logic [5:0] FRAME_LAST  = 6'd63;
  localparam logic [3:0] FIELD_LAST  = 4'd11;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  localparam logic [HDR_W-1:0] HEADER_RESET = 32'h4144_3030;

  localparam logic [1:0] ITEM_MEAS     = 2'd0;
  localparam logic [1:0] ITEM_STATUS   = 2'd1;
  localparam logic [1:0] ITEM_MISMATCH = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [7:0]         rx_byte;
  } asfp_word_t;

  typedef struct packed {
    logic [1:0]               item_kind;
    logic [3:0]               field_index;
    logic signed [VALUE_W-1:0] field_value;
    logic [1:0]               decimal_places;
    logic [6:0]               error_code;
    logic                     solar_charge;
    logic                     inverter_on;
    logic [1:0]               battery_state;
    logic                     overload;
    logic                     charging;
  } asfp_result_t;

  // last frame position of each measurement field
  function automatic logic [5:0] field_last_byte(input logic [3:0] idx);
    logic [5:0] r;
    unique case (idx)
      4'd0:    r = 6'd7;
      4'd1:    r = 6'd11;
      4'd2:    r = 6'd15;
      4'd3:    r = 6'd19;
      4'd4:    r = 6'd23;
      4'd5:    r = 6'd27;
      4'd6:    r = 6'd31;
      4'd7:    r = 6'd35;
      4'd8:    r = 6'd39;
      4'd9:    r = 6'd43;
      4'd10:   r = 6'd47;
      default: r = 6'd55;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] field_decimals(input logic [3:0] idx);
    logic [1:0] r;
    unique case (idx)
      4'd2, 4'd4, 4'd6, 4'd11: r = 2'd2;
      default:                 r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

/* hdl/asfp_byte_if.sv */
// input channel carrying one received byte per word
interface asfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/asfp_result_if.sv */
// result channel carrying one parsed item per word
interface asfp_result_if;
  import asfp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                item_kind;
  logic [3:0]                field_index;
  logic signed [VALUE_W-1:0] field_value;
  logic [1:0]                decimal_places;
  logic [6:0]                error_code;
  logic                      solar_charge;
  logic                      inverter_on;
  logic [1:0]                battery_state;
  logic                      overload;
  logic                      charging;

  modport source (
    output valid, input ready,
    output item_kind, field_index, field_value, decimal_places, error_code,
    output solar_charge, inverter_on, battery_state, overload, charging
  );
  modport sink (
    input valid, output ready,
    input item_kind, field_index, field_value, decimal_places, error_code,
    input solar_charge, inverter_on, battery_state, overload, charging
  );
endinterface

/* hdl/asfp_in_reg.sv */
// input register holding one received byte until the parser takes it
module asfp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               take,
  output asfp_pkg::asfp_word_t held
);
  import asfp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      byte_nxt  = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign held.valid   = valid_r;
  assign held.rx_byte = byte_r;
endmodule

/* hdl/asfp_parser.sv */
// frame sync, header check, field parsing and status summary, one byte per step
module asfp_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [7:0]                 rx_byte,
  input  logic [asfp_pkg::HDR_W-1:0] header_word,
  output logic                       res_valid,
  output asfp_pkg::asfp_result_t     res
);
  import asfp_pkg::*;

  localparam logic [1:0] SYNC_HUNT_LF  = 2'd0;
  localparam logic [1:0] SYNC_WANT_CR  = 2'd1;
  localparam logic [1:0] SYNC_IN_FRAME = 2'd2;

  localparam logic [1:0] PARSE_SKIP   = 2'd0;
  localparam logic [1:0] PARSE_DIGITS = 2'd1;
  localparam logic [1:0] PARSE_DONE   = 2'd2;

  typedef struct packed {
    logic [1:0]         phase;
    logic               neg;
    logic [VALUE_W-1:0] acc;
  } parse_st_t;

  typedef struct packed {
    logic       neg;
    logic [6:0] mag;
  } two_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // one atoi step
  function automatic parse_st_t parse_char(input logic [7:0] c, input parse_st_t s);
    parse_st_t  r;
    logic [VALUE_W-1:0] x10;
    r   = s;
    x10 = (s.acc << 3) + (s.acc << 1);
    unique case (s.phase)
      PARSE_SKIP: begin
        if (is_white(c)) begin
          r = s;
        end else if (c == "+") begin
          r.phase = PARSE_DIGITS;
        end else if (c == "-") begin
          r.neg   = 1'b1;
          r.phase = PARSE_DIGITS;
        end else if (is_digit(c)) begin
          r.acc   = {{(VALUE_W-4){1'b0}}, c[3:0]};
          r.phase = PARSE_DIGITS;
        end else begin
          r.phase = PARSE_DONE;
        end
      end
      PARSE_DIGITS: begin
        if (is_digit(c)) begin
          r.acc = x10 + {{(VALUE_W-4){1'b0}}, c[3:0]};
        end else begin
          r.phase = PARSE_DONE;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // two-character atoi, magnitude and sign
  function automatic two_t parse_two(input logic [7:0] a, input logic [7:0] b);
    two_t       r;
    logic [6:0] da;
    logic [6:0] db;
    da    = {3'b000, a[3:0]};
    db    = {3'b000, b[3:0]};
    r.neg = 1'b0;
    r.mag = '0;
    if (is_white(a)) begin
      if (b == "-") begin
        r.neg = 1'b1;
      end else if (is_digit(b)) begin
        r.mag = db;
      end
    end else if (a == "+" || a == "-") begin
      r.neg = (a == "-");
      if (is_digit(b)) begin
        r.mag = db;
      end
    end else if (is_digit(a)) begin
      r.mag = is_digit(b) ? (da << 3) + (da << 1) + db : da;
    end
    return r;
  endfunction

  logic [1:0]         sync_r, sync_nxt;
  logic [5:0]         pos_r, pos_nxt;
  logic [3:0]         fnum_r, fnum_nxt;
  logic               hbad_r, hbad_nxt;
  parse_st_t          pst_r, pst_nxt;
  logic [7:0]         stat_r [8];
  logic [7:0]         stat_nxt [8];

  parse_st_t          pst_step;
  logic [3:0]         fidx;
  logic [7:0]         want;
  logic               hdr_miss;
  two_t               err_p;
  two_t               load_p;
  logic [VALUE_W-1:0] value;

  assign fidx     = (fnum_r > FIELD_LAST) ? FIELD_LAST : fnum_r;
  assign pst_step = parse_char(rx_byte, pst_r);
  assign value    = pst_step.neg ? ('0 - pst_step.acc) : pst_step.acc;
  assign err_p    = parse_two(stat_r[0], stat_r[1]);
  assign load_p   = parse_two(stat_r[5], stat_r[6]);
  assign hdr_miss = (rx_byte != want);

  always_comb begin
    unique case (pos_r[1:0])
      2'd0:    want = header_word[31:24];
      2'd1:    want = header_word[23:16];
      2'd2:    want = header_word[15:8];
      default: want = header_word[7:0];
    endcase
  end

  always_comb begin
    sync_nxt  = sync_r;
    pos_nxt   = pos_r;
    fnum_nxt  = fnum_r;
    hbad_nxt  = hbad_r;
    pst_nxt   = pst_r;
    stat_nxt  = stat_r;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      unique case (sync_r)
        SYNC_WANT_CR: begin
          sync_nxt = (rx_byte == CHAR_CR) ? SYNC_IN_FRAME : SYNC_HUNT_LF;
          pos_nxt  = '0;
          fnum_nxt = '0;
          hbad_nxt = 1'b0;
          pst_nxt  = '{phase: PARSE_SKIP, neg: 1'b0, acc: '0};
        end
        SYNC_IN_FRAME: begin
          if (pos_r <= HEADER_LAST) begin
            if (hdr_miss) begin
              hbad_nxt = 1'b1;
            end
            if (pos_r == HEADER_LAST && (hbad_r || hdr_miss)) begin
              res_valid     = 1'b1;
              res.item_kind = ITEM_MISMATCH;
            end
          end else if (!hbad_r && pos_r < STATUS_BASE) begin
            pst_nxt = pst_step;
            if (pos_r == field_last_byte(fidx)) begin
              res_valid          = 1'b1;
              res.item_kind      = ITEM_MEAS;
              res.field_index    = fidx;
              res.field_value    = $signed(value);
              res.decimal_places = field_decimals(fidx);
              fnum_nxt           = fnum_r + 4'd1;
              pst_nxt            = '{phase: PARSE_SKIP, neg: 1'b0, acc: '0};
            end
          end else if (!hbad_r) begin
            stat_nxt[pos_r[2:0]] = rx_byte;
            if (pos_r == FRAME_LAST) begin
              res_valid         = 1'b1;
              res.item_kind     = ITEM_STATUS;
              res.error_code    = err_p.mag;
              res.solar_charge  = (stat_r[2] != CHAR_ZERO);
              res.inverter_on   = (stat_r[3] != CHAR_ZERO);
              res.battery_state = (stat_r[4] == CHAR_ZERO) ? 2'd0 :
                                  ((stat_r[4] == CHAR_ONE) ? 2'd1 : 2'd2);
              res.overload      = !load_p.neg && (load_p.mag == 7'd2);
              res.charging      = (rx_byte != CHAR_ZERO);
            end
          end
          if (pos_r == FRAME_LAST) begin
            sync_nxt = SYNC_HUNT_LF;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        default: begin
          sync_nxt = (rx_byte == CHAR_LF) ? SYNC_WANT_CR : SYNC_HUNT_LF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_HUNT_LF;
      pos_r  <= '0;
      fnum_r <= '0;
      hbad_r <= 1'b0;
      pst_r  <= '{phase: PARSE_SKIP, neg: 1'b0, acc: '0};
      for (int i = 0; i < 8; i++) begin
        stat_r[i] <= '0;
      end
    end else begin
      sync_r <= sync_nxt;
      pos_r  <= pos_nxt;
      fnum_r <= fnum_nxt;
      hbad_r <= hbad_nxt;
      pst_r  <= pst_nxt;
      stat_r <= stat_nxt;
    end
  end
endmodule

/* hdl/asfp_out_reg.sv */
// result register, holds a word until the receiver takes it
module asfp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   res_valid,
  input  asfp_pkg::asfp_result_t res,
  input  logic                   out_ready,
  output logic                   out_valid,
  output asfp_pkg::asfp_result_t out_res,
  output logic                   free
);
  import asfp_pkg::*;

  logic         valid_r, valid_nxt;
  asfp_result_t res_r, res_nxt;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = res_valid;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
endmodule

/* hdl/ascii_status_frame_parser_core.sv */
// top level of the ascii status frame parser
//
// in_rx carries received serial bytes, one per word. The block hunts for a
// line feed directly followed by a carriage return, then frames 64 bytes:
// a 4-byte header checked against the header register, twelve decimal
// measurement fields and eight status characters.
// out_res carries results: a measurement on the last byte of each field,
// a status summary on byte 63, or a header mismatch on byte 3.
// cfg_wr_en/cfg_wr_data write the header register; write only while idle.
// Throughput is one byte per cycle while out_res does not stall. A byte
// waits in the input register until the parser takes it, and its result is
// registered as it is taken, so a result is shown in the cycle after that.
// When out_res stalls the parser holds; the input register takes a byte
// only while it is empty, then ready drops until the result word is taken.
// Synchronous reset returns to line feed hunting, empties both registers
// and sets the header register to "AD00".
module ascii_status_frame_parser_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [asfp_pkg::HDR_W-1:0] cfg_wr_data,
  asfp_byte_if.sink                  in_rx,
  asfp_result_if.source              out_res
);
  import asfp_pkg::*;

  logic [HDR_W-1:0] header_word_r;
  asfp_word_t       held;
  logic             step;
  logic             free;
  logic             res_valid;
  asfp_result_t     res;
  asfp_result_t     res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_word_r <= HEADER_RESET;
    end else if (cfg_wr_en) begin
      header_word_r <= cfg_wr_data;
    end
  end

  assign step = held.valid && free;

  asfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rx.valid),
    .in_byte  (in_rx.rx_byte),
    .in_ready (in_rx.ready),
    .take     (step),
    .held     (held)
  );

  asfp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (held.rx_byte),
    .header_word (header_word_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  asfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .out_res   (res_q),
    .free      (free)
  );

  assign out_res.item_kind      = res_q.item_kind;
  assign out_res.field_index    = res_q.field_index;
  assign out_res.field_value    = res_q.field_value;
  assign out_res.decimal_places = res_q.decimal_places;
  assign out_res.error_code     = res_q.error_code;
  assign out_res.solar_charge   = res_q.solar_charge;
  assign out_res.inverter_on    = res_q.inverter_on;
  assign out_res.battery_state  = res_q.battery_state;
  assign out_res.overload       = res_q.overload;
  assign out_res.charging       = res_q.charging;
endmodule

/* hdl/asfp_checker.sv */
// port-level checks on the parser result channel, bound to the top level
`include "ascii_status_frame_parser_core_defines.svh"

module asfp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_item_kind,
  input logic [3:0]                        out_field_index,
  input logic signed [asfp_pkg::VALUE_W-1:0] out_field_value,
  input logic [1:0]                        out_decimal_places,
  input logic [6:0]                        out_error_code,
  input logic                              out_solar_charge,
  input logic                              out_inverter_on,
  input logic [1:0]                        out_battery_state,
  input logic                              out_overload,
  input logic                              out_charging
);
  import asfp_pkg::*;

  // a stalled word keeps its kind and value
  `ASFP_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_item_kind) && $stable(out_field_value))

  `ASFP_ASSERT_IMP(a_meas_fields, out_valid && out_item_kind == ITEM_MEAS, out_field_index <= FIELD_LAST && (out_decimal_places == 2'd1 || out_decimal_places == 2'd2))

  // status flags only on a status summary
  `ASFP_ASSERT_IMP(a_status_clear, out_valid && out_item_kind != ITEM_STATUS, out_error_code == 7'd0 && !out_solar_charge && !out_inverter_on && out_battery_state == 2'd0 && !out_overload && !out_charging)

  `ASFP_ASSERT_IMP(a_mismatch_clear, out_valid && out_item_kind != ITEM_MEAS, out_field_index == 4'd0 && out_field_value == 0 && out_decimal_places == 2'd0)
endmodule

bind ascii_status_frame_parser_core asfp_checker u_asfp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_res.valid),
  .out_ready          (out_res.ready),
  .out_item_kind      (out_res.item_kind),
  .out_field_index    (out_res.field_index),
  .out_field_value    (out_res.field_value),
  .out_decimal_places (out_res.decimal_places),
  .out_error_code     (out_res.error_code),
  .out_solar_charge   (out_res.solar_charge),
  .out_inverter_on    (out_res.inverter_on),
  .out_battery_state  (out_res.battery_state),
  .out_overload       (out_res.overload),
  .out_charging       (out_res.charging)
);

/* sim/tb_top.sv */
// self-checking testbench for the ascii status frame parser: byte streams against a predictor
`timescale 1ns / 1ps

module tb_top;
  import asfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 160;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TWO   = 8'h32;

  typedef enum logic [1:0] {HUNT_LF, WANT_CR, IN_FRAME} sync_t;
  typedef enum logic [1:0] {SKIP_WS, IN_DIGITS, NUM_DONE} num_phase_t;

  typedef struct packed {
    num_phase_t         phase;
    logic               neg;
    logic [VALUE_W-1:0] acc;
  } num_parse_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [HDR_W-1:0] cfg_wr_data;

  asfp_byte_if   in_rx ();
  asfp_result_if out_res ();

  ascii_status_frame_parser_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_rx       (in_rx),
    .out_res     (out_res)
  );

  // predictor copy of the block state
  logic [HDR_W-1:0] hdr_reg;
  sync_t            sync_st;
  logic [5:0]       frame_pos;
  logic [3:0]       field_num;
  num_parse_t       field_parse;
  logic             hdr_bad;
  logic [7:0]       status_chars [8];
  asfp_result_t     expected_items [$];

  logic [7:0] frame_buf [64];

  int errors = 0;
  int cycle_count = 0;
  int frames_sent = 0;
  int bytes_sent = 0;
  int n_meas = 0;
  int n_status = 0;
  int n_mismatch = 0;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_req;
  int hold_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_items.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random ready, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // one atoi step on a character
  function automatic num_parse_t num_step(input num_parse_t s, input logic [7:0] c);
    num_parse_t r;
    logic       digit;
    r = s;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (s.phase == SKIP_WS) begin
      if (c == CHAR_PLUS) begin
        r.phase = IN_DIGITS;
      end else if (c == CHAR_MINUS) begin
        r.neg = 1'b1;
        r.phase = IN_DIGITS;
      end else if (digit) begin
        r.acc = VALUE_W'(c - CHAR_ZERO);
        r.phase = IN_DIGITS;
      end else if (c != CHAR_SPACE && !(c >= 8'h09 && c <= 8'h0D)) begin
        r.phase = NUM_DONE;
      end
    end else if (s.phase == IN_DIGITS) begin
      if (digit) r.acc = VALUE_W'(r.acc * 10 + (c - CHAR_ZERO));
      else r.phase = NUM_DONE;
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] c);
    asfp_result_t r;
    logic         hit;
    num_parse_t   err;
    num_parse_t   load;
    int           p;
    int           f;
    r = '0;
    hit = 1'b0;
    p = frame_pos;
    case (sync_st)
      WANT_CR: begin
        sync_st = (c == CHAR_CR) ? IN_FRAME : HUNT_LF;
        frame_pos = '0;
        field_num = '0;
        hdr_bad = 1'b0;
        field_parse = '0;
      end
      IN_FRAME: begin
        if (p < 4) begin
          if (c != hdr_reg[8*(3-p) +: 8]) hdr_bad = 1'b1;
          if (p == 3 && hdr_bad) begin
            r.item_kind = ITEM_MISMATCH;
            hit = 1'b1;
          end
        end else if (!hdr_bad && p < 56) begin
          f = (field_num < 12) ? field_num : 11;
          field_parse = num_step(field_parse, c);
          if (p == ((f < 11) ? 7 + 4*f : 55)) begin
            r.item_kind = ITEM_MEAS;
            r.field_index = 4'(f);
            r.field_value = field_parse.neg ? -field_parse.acc : field_parse.acc;
            r.decimal_places = (f == 2 || f == 4 || f == 6 || f == 11) ? 2'd2 : 2'd1;
            hit = 1'b1;
            field_num = field_num + 4'd1;
            field_parse = '0;
          end
        end else if (!hdr_bad) begin
          status_chars[p-56] = c;
          if (p == 63) begin
            err = num_step(num_step('0, status_chars[0]), status_chars[1]);
            load = num_step(num_step('0, status_chars[5]), status_chars[6]);
            r.item_kind = ITEM_STATUS;
            r.error_code = err.acc[6:0];
            r.solar_charge = (status_chars[2] != CHAR_ZERO);
            r.inverter_on = (status_chars[3] != CHAR_ZERO);
            r.battery_state = (status_chars[4] == CHAR_ZERO) ? 2'd0 :
                              (status_chars[4] == CHAR_ONE) ? 2'd1 : 2'd2;
            r.overload = !load.neg && load.acc == 2;
            r.charging = (status_chars[7] != CHAR_ZERO);
            hit = 1'b1;
          end
        end
        if (p == 63) begin
          sync_st = HUNT_LF;
          frame_pos = '0;
        end else begin
          frame_pos = frame_pos + 6'd1;
        end
      end
      default: sync_st = (c == CHAR_LF) ? WANT_CR : HUNT_LF;
    endcase
    if (hit) expected_items.push_back(r);
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    asfp_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d value %0d", $time,
                 out_res.item_kind, out_res.field_value);
      end else begin
        want = expected_items.pop_front();
        check_field("item_kind", want.item_kind, out_res.item_kind);
        check_field("field_index", want.field_index, out_res.field_index);
        check_field("field_value", want.field_value, out_res.field_value);
        check_field("decimal_places", want.decimal_places, out_res.decimal_places);
        check_field("error_code", want.error_code, out_res.error_code);
        check_field("solar_charge", want.solar_charge, out_res.solar_charge);
        check_field("inverter_on", want.inverter_on, out_res.inverter_on);
        check_field("battery_state", want.battery_state, out_res.battery_state);
        check_field("overload", want.overload, out_res.overload);
        check_field("charging", want.charging, out_res.charging);
        case (want.item_kind)
          ITEM_MEAS:   n_meas++;
          ITEM_STATUS: n_status++;
          default:     n_mismatch++;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_rx.valid <= 1'b0;
      @(negedge clk);
    end
    in_rx.valid <= 1'b1;
    in_rx.rx_byte <= b;
    @(posedge clk);
    while (!in_rx.ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  // stop offering and let the block empty out
  task automatic wait_idle();
    @(negedge clk);
    in_rx.valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input logic [HDR_W-1:0] w);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hdr_reg = w;
  endtask

  function automatic int field_start(input int f);
    return (f < 11) ? 4 + 4*f : 48;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_flag();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return $urandom_range(1) ? CHAR_ONE : CHAR_ZERO;
  endfunction

  function automatic logic [7:0] white_char();
    case ($urandom_range(5))
      0:       return CHAR_SPACE;
      1:       return 8'h09;
      2:       return CHAR_LF;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CHAR_CR;
    endcase
  endfunction

  task automatic put_text(input int at, input string s);
    int k;
    for (k = 0; k < s.len(); k++) frame_buf[at+k] = s[k];
  endtask

  task automatic build_field(input int at, input int width);
    int style;
    int lead;
    int k;
    style = $urandom_range(9);
    if (style == 8) begin
      for (k = 0; k < width; k++) frame_buf[at+k] = 8'($urandom_range(255));
    end else begin
      lead = $urandom_range(width - 1);
      for (k = 0; k < lead; k++) frame_buf[at+k] = (style == 6) ? white_char() : CHAR_SPACE;
      if ($urandom_range(3) == 0) begin
        frame_buf[at+k] = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
        k++;
      end
      // sign or blanks followed by junk
      if (style == 9 && k < width) begin
        frame_buf[at+k] = 8'h41 + 8'($urandom_range(25));
        k++;
      end
      for (; k < width; k++) begin
        frame_buf[at+k] = (style == 7 && $urandom_range(3) == 0) ?
                          8'($urandom_range(255)) : rand_digit();
      end
    end
  endtask

  task automatic build_status();
    frame_buf[56] = rand_digit();
    frame_buf[57] = rand_digit();
    case ($urandom_range(5))
      0: frame_buf[56] = CHAR_ZERO;
      1: frame_buf[56] = CHAR_SPACE;
      2: frame_buf[56] = CHAR_MINUS;
      3: begin
        frame_buf[56] = 8'($urandom_range(255));
        frame_buf[57] = 8'($urandom_range(255));
      end
      default: ;
    endcase
    frame_buf[58] = rand_flag();
    frame_buf[59] = rand_flag();
    frame_buf[63] = rand_flag();
    case ($urandom_range(3))
      0:       frame_buf[60] = CHAR_ZERO;
      1:       frame_buf[60] = CHAR_ONE;
      2:       frame_buf[60] = CHAR_TWO;
      default: frame_buf[60] = 8'($urandom_range(255));
    endcase
    frame_buf[61] = CHAR_ZERO;
    frame_buf[62] = $urandom_range(1) ? CHAR_TWO : rand_digit();
    case ($urandom_range(6))
      0: frame_buf[61] = CHAR_SPACE;
      1: frame_buf[61] = CHAR_MINUS;
      2: frame_buf[61] = CHAR_PLUS;
      3: begin
        frame_buf[61] = CHAR_TWO;
        frame_buf[62] = CHAR_SPACE;
      end
      4: begin
        frame_buf[61] = 8'($urandom_range(255));
        frame_buf[62] = 8'($urandom_range(255));
      end
      default: ;
    endcase
  endtask

  task automatic fill_random_frame(input logic [HDR_W-1:0] hdr);
    int f;
    for (f = 0; f < 4; f++) frame_buf[f] = hdr[8*(3-f) +: 8];
    for (f = 0; f < 12; f++) build_field(field_start(f), (f < 11) ? 4 : 8);
    build_status();
  endtask

  // sync pair, then the first upto bytes of the frame buffer
  task automatic send_frame(input int upto);
    int k;
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    for (k = 0; k < upto; k++) send_byte(frame_buf[k]);
    frames_sent++;
  endtask

  task automatic test_field_extremes();
    fill_random_frame(hdr_reg);
    put_text(field_start(0), "9999");
    put_text(field_start(1), "-999");
    put_text(field_start(2), "   0");
    put_text(field_start(3), "+123");
    put_text(field_start(4), "  -1");
    put_text(field_start(5), "0000");
    put_text(field_start(6), " 42 ");
    put_text(field_start(7), "7x99");
    put_text(field_start(8), "+   ");
    put_text(field_start(9), "-   ");
    put_text(field_start(10), "    ");
    put_text(field_start(11), "99999999");
    put_text(56, "00111021");
    send_frame(64);
    // every kind of white space, stray signs and junk
    fill_random_frame(hdr_reg);
    put_text(field_start(0), "\t\n12");
    put_text(field_start(1), "\013-34");
    put_text(field_start(2), " \014\0155");
    put_text(field_start(3), " - 5");
    put_text(field_start(4), "-x12");
    put_text(field_start(5), "12-3");
    put_text(field_start(6), "++12");
    put_text(field_start(7), "0x1F");
    put_text(field_start(8), "\3771  ");
    put_text(field_start(9), " +07");
    put_text(field_start(10), "-0  ");
    put_text(field_start(11), "-9999999");
    put_text(56, "-5000-20");
    send_frame(64);
  endtask

  task automatic test_status_flags();
    fill_random_frame(hdr_reg);
    put_text(56, "00000000");
    send_frame(64);
    fill_random_frame(hdr_reg);
    put_text(56, " 710x 20");
    send_frame(64);
    fill_random_frame(hdr_reg);
    put_text(56, "990112 1");
    send_frame(64);
    fill_random_frame(hdr_reg);
    put_text(56, " 0\377\3772+2\377");
    send_frame(64);
  endtask

  task automatic test_sync_hunt();
    int k;
    fill_random_frame(hdr_reg);
    send_byte(CHAR_LF);
    send_byte(8'h41);
    // a second lf in the cr slot is swallowed, so this cr frames nothing
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    for (k = 0; k < 8; k++) send_byte(frame_buf[k]);
    send_byte(CHAR_CR);
    send_frame(64);
  endtask

  task automatic test_header_mismatch();
    int p;
    int k;
    for (p = 0; p < 5; p += 2) begin
      fill_random_frame(hdr_reg);
      for (k = 0; k < 4; k++) begin
        if (k == p || p == 4) frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(255, 1));
      end
      send_frame(64);
    end
  endtask

  task automatic test_header_register();
    logic [HDR_W-1:0] w;
    int               i;
    for (i = 0; i < 4; i++) begin
      case (i)
        0:       w = '0;
        1:       w = '1;
        2:       w = {CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR};
        default: w = HEADER_RESET;
      endcase
      wait_idle();
      write_header(w);
      fill_random_frame(hdr_reg);
      // odd passes spoil the last header byte
      if (i % 2 == 1) frame_buf[3] = frame_buf[3] ^ 8'($urandom_range(255, 1));
      send_frame(64);
    end
  endtask

  task automatic test_output_stall();
    wait_idle();
    src_idle_pct = 0;
    @(posedge clk);
    hold_req = 90;
    fill_random_frame(hdr_reg);
    send_frame(64);
    src_idle_pct = 35;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int   frame_bytes;
    int   pick;
    int   n;
    int   k;
    logic hdr_moved;
    frame_bytes = 0;
    hdr_moved = 1'b0;
    while (frame_bytes < RANDOM_BYTES) begin
      // a calm stretch with neither side idling
      if (frame_bytes < 100) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = 35;
        sink_idle_pct = 35;
      end
      if (!hdr_moved && frame_bytes >= RANDOM_BYTES / 2) begin
        wait_idle();
        write_header($urandom());
        hdr_moved = 1'b1;
      end
      pick = $urandom_range(99);
      fill_random_frame(hdr_reg);
      if (pick < 10) begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
      end else if (pick < 20) begin
        k = $urandom_range(3);
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(255, 1));
        send_frame(64);
        frame_bytes += 66;
      end else if (pick < 28) begin
        // cut short: the next frame lands mid-frame
        n = $urandom_range(63, 1);
        send_frame(n);
        frame_bytes += n + 2;
      end else begin
        send_frame(64);
        frame_bytes += 66;
      end
    end
    src_idle_pct = 35;
    sink_idle_pct = 35;
    wait_idle();
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_rx.valid = 1'b0;
    in_rx.rx_byte = '0;
    out_res.ready = 1'b0;
    src_idle_pct = 35;
    sink_idle_pct = 35;
    hold_req = 0;
    hold_left = 0;
    hdr_reg = HEADER_RESET;
    sync_st = HUNT_LF;
    frame_pos = '0;
    field_num = '0;
    field_parse = '0;
    hdr_bad = 1'b0;
    for (k = 0; k < 8; k++) status_chars[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_status_flags();
    test_sync_hunt();
    test_header_mismatch();
    test_header_register();
    test_output_stall();
    test_random_traffic();
    wait_idle();

    $display("sent %0d bytes in %0d framed sequences, header register rewritten five times",
             bytes_sent, frames_sent);
    $display("checked %0d measurements, %0d status summaries, %0d header mismatches",
             n_meas, n_status, n_mismatch);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
